// File: rtl/core/bkem_pkg.sv
package bkem_pkg;

  localparam int MaxPattern = 31;
  localparam int MaxErrors  = 4;
  localparam int Levels     = MaxErrors + 1;
  localparam int QueueDepth = 2;
  localparam int CfgWidth   = 64;

  typedef logic [MaxPattern-1:0] vec_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT_A  = 3'd0,
    REG_PAT_B  = 3'd1,
    REG_PAT_C  = 3'd2,
    REG_PAT_D  = 3'd3,
    REG_LENGTH = 3'd4,
    REG_LIMIT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic       match;
    logic [2:0] fewest_errors;
  } out_item_t;

  // settings seen by front and back
  typedef struct packed {
    logic [MaxPattern-1:0][7:0] pattern;
    logic [4:0]                 used_len;
    logic [2:0]                 limit;
  } cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    vec_t mask;
    logic restart;
  } job_t;

  // level d starts with its lowest d positions set
  function automatic vec_t init_level(input int d);
    vec_t v;
    for (int i = 0; i < MaxPattern; i++) begin
      v[i] = (i < d);
    end
    return v;
  endfunction

endpackage

// File: rtl/core/bkem_front.sv
module bkem_front import bkem_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  // take a byte whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // compare the byte with every pattern position in use
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      job_o.mask[i] = (5'(i) < cfg_i.used_len) &&
                      (cfg_i.pattern[i] == in_data_i.text_byte);
    end
    job_o.restart = in_data_i.restart;
  end

endmodule

// File: rtl/core/bkem_queue.sv
module bkem_queue import bkem_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

// File: rtl/core/bkem_back.sv
module bkem_back import bkem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  vec_t       levels_q [Levels];
  vec_t       cur      [Levels];
  vec_t       nxt      [Levels];
  logic [4:0] last_idx;
  logic [2:0] fewest;
  logic       out_valid_q;
  out_item_t  out_q;

  // advance when the output register is free or being drained
  assign pop_o = job_valid_i && (!out_valid_q || out_ready_i);

  // level update chain: match, insertion, substitution, deletion
  always_comb begin
    for (int d = 0; d < Levels; d++) begin
      cur[d] = job_i.restart ? init_level(d) : levels_q[d];
    end
    nxt[0] = ((cur[0] << 1) | vec_t'(1)) & job_i.mask;
    for (int d = 1; d < Levels; d++) begin
      nxt[d] = (((cur[d] << 1) | vec_t'(1)) & job_i.mask)
             | cur[d-1]
             | ((cur[d-1] << 1) | vec_t'(1))
             | ((nxt[d-1] << 1) | vec_t'(1));
    end
  end

  // lowest level reaching the last pattern position
  always_comb begin
    last_idx = cfg_i.used_len - 5'd1;
    fewest   = 3'(Levels);
    for (int d = Levels - 1; d >= 0; d--) begin
      if (nxt[d][last_idx]) begin
        fewest = 3'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < Levels; d++) begin
        levels_q[d] <= init_level(d);
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int d = 0; d < Levels; d++) begin
          levels_q[d] <= nxt[d];
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.match         <= (fewest <= cfg_i.limit);
      out_q.fewest_errors <= fewest;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pop_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q) else $error("popped job gave no result");
  a_level_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    levels_q[1][0]) else $error("level one lost its base position");
  a_match_cons : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.match |-> out_q.fewest_errors <= 3'(MaxErrors))
    else $error("match reported with no matching level");

endmodule

// File: rtl/core/bitparallel_k_error_matcher_top.sv
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------
// in       | in_valid_i / in_ready_o   | in_data_i (text_byte, restart)
// out      | out_valid_o / out_ready_i | out_data_o (match, fewest_errors)
// cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one text byte per cycle while out_ready_i stays high; a result is
// registered twice after its byte is taken (front mask into the two-entry
// queue, then the level update into the result register).
// reset puts every level vector at its start value and loads the register
// defaults; there is no clearing pass.
// a stalled output fills the queue, after which in_ready_o drops.
module bitparallel_k_error_matcher_top import bkem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  logic [MaxPattern-1:0][7:0] pattern_q;
  logic [4:0]                 length_q;
  logic [2:0]                 limit_q;
  cfg_t                       cfg;
  logic                       full;
  logic                       push;
  logic                       pop;
  logic                       job_valid;
  job_t                       job_in;
  job_t                       job_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= 5'(MaxPattern);
      limit_q   <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_A: begin
          for (int b = 0; b < 8; b++) pattern_q[b] <= cfg_wdata_i[8*b +: 8];
        end
        REG_PAT_B: begin
          for (int b = 0; b < 8; b++) pattern_q[8+b] <= cfg_wdata_i[8*b +: 8];
        end
        REG_PAT_C: begin
          for (int b = 0; b < 8; b++) pattern_q[16+b] <= cfg_wdata_i[8*b +: 8];
        end
        REG_PAT_D: begin
          for (int b = 0; b < MaxPattern - 24; b++) begin
            pattern_q[24+b] <= cfg_wdata_i[8*b +: 8];
          end
        end
        REG_LENGTH: length_q <= cfg_wdata_i[4:0];
        REG_LIMIT:  limit_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // effective length and error limit
  always_comb begin
    cfg.pattern  = pattern_q;
    cfg.used_len = (length_q == 5'd0) ? 5'd1 : length_q;
    cfg.limit    = (limit_q > 3'(MaxErrors)) ? 3'(MaxErrors) : limit_q;
  end

  bkem_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  bkem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  bkem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
